// ===== rtl/core/dbcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcd_pkg
// Shared widths, constants and segment decode for the debounced button
// counter display.
// ----------------------------------------------------------------------------
package dbcd_pkg;

    localparam int NUM_BUTTONS_DEF = 8;
    localparam int MAX_BUTTONS     = 8;

    localparam int LEVEL_W = 8;
    localparam int SEG_W   = 8;
    localparam int ADDR_W  = 3;
    localparam int COUNT_W = 10;
    localparam int SUM_W   = COUNT_W + 1;
    localparam int HIST_W  = 16;
    localparam int POS_W   = 2;
    localparam int DIGIT_W = 4;

    localparam logic [HIST_W-1:0]  HIST_FORCE  = 16'hE000;
    localparam logic [HIST_W-1:0]  HIST_ACCEPT = 16'hF000;
    localparam logic [SUM_W-1:0]   COUNT_LIMIT = 11'd1023;
    localparam logic [SEG_W-1:0]   BLANK_CODE  = 8'hFF;
    localparam logic [ADDR_W-1:0]  BLANK_ADDR  = 3'd0;

    localparam logic [COUNT_W-1:0] SHOW_TENS      = 10'd10;
    localparam logic [COUNT_W-1:0] SHOW_HUNDREDS  = 10'd100;
    localparam logic [COUNT_W-1:0] SHOW_THOUSANDS = 10'd1000;

    localparam logic [ADDR_W-1:0] ADDR_UNITS     = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_TENS      = 3'd1;
    localparam logic [ADDR_W-1:0] ADDR_HUNDREDS  = 3'd3;
    localparam logic [ADDR_W-1:0] ADDR_THOUSANDS = 3'd4;

    // Reciprocal multipliers: x/10 = (x*205)>>11, x/100 = (x*41)>>12 for x < 1024
    localparam logic [7:0] RECIP_TEN     = 8'd205;
    localparam int         RECIP_TEN_SH  = 11;
    localparam logic [5:0] RECIP_HUND    = 6'd41;
    localparam int         RECIP_HUND_SH = 12;

    typedef enum logic [POS_W-1:0] {
        POS_UNITS     = 2'd0,
        POS_TENS      = 2'd1,
        POS_HUNDREDS  = 2'd2,
        POS_THOUSANDS = 2'd3
    } t_digit_pos;

    function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] code;
        unique case (digit)
            4'd0:    code = 8'hC0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'hA4;
            4'd3:    code = 8'hB0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = BLANK_CODE;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/core/dbcd_chan_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcd_chan_if
// Valid/ready channels: button sample requests in, display requests out.
// ----------------------------------------------------------------------------
interface dbcd_btn_if;
    logic                          valid;
    logic                          ready;
    logic [dbcd_pkg::LEVEL_W-1:0]  button_levels;

    modport source (output valid, output button_levels, input ready);
    modport sink   (input valid, input button_levels, output ready);
endinterface

interface dbcd_disp_if;
    logic                          valid;
    logic                          ready;
    logic [dbcd_pkg::SEG_W-1:0]    segment_pattern;
    logic [dbcd_pkg::ADDR_W-1:0]   digit_address;
    logic [dbcd_pkg::COUNT_W-1:0]  count_value;

    modport source (output valid, output segment_pattern, output digit_address,
                    output count_value, input ready);
    modport sink   (input valid, input segment_pattern, input digit_address,
                    input count_value, output ready);
endinterface

// ===== rtl/core/debounced_button_counter_display_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_button_counter_display_unit
// Shift-register debounce of eight buttons, running count, multiplexed
// seven-segment digit output.
// ----------------------------------------------------------------------------
// Usage:
//   i_btn carries one request per tick: eight raw active-low button levels.
//   o_disp returns one request per tick: the segment pattern and decoder
//   address of the tick's digit, plus the updated count.
//   Three register stages: input, state update (debounce histories, count,
//   digit position), digit decode into the output register. A result passes
//   through the input, state and output registers on its way to o_disp.
//   Throughput is one request per cycle while o_disp is ready; each stage
//   advances on its own, so up to three requests are held while o_disp is
//   stalled, after which i_btn.ready drops until the sink takes a result.
//   Reset clears all histories, the count and the digit position (units
//   digit first) and empties every stage.
//   Leading zero digits come out blank: pattern 0xFF, address 0.
// ----------------------------------------------------------------------------
module debounced_button_counter_display_unit #(
    parameter int NUM_BUTTONS = dbcd_pkg::NUM_BUTTONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dbcd_btn_if.sink    i_btn,
    dbcd_disp_if.source o_disp
);

    localparam int HW = dbcd_pkg::HIST_W;
    localparam int CW = dbcd_pkg::COUNT_W;
    localparam int SW = dbcd_pkg::SUM_W;
    localparam int DW = dbcd_pkg::DIGIT_W;

    logic                          r_in_v;
    logic [NUM_BUTTONS-1:0]        r_in_lvl;
    logic                          r_mid_v;
    logic [CW-1:0]                 r_mid_count;
    dbcd_pkg::t_digit_pos          r_mid_pos;
    logic                          r_out_v;
    logic [dbcd_pkg::SEG_W-1:0]    r_out_seg;
    logic [dbcd_pkg::ADDR_W-1:0]   r_out_addr;
    logic [CW-1:0]                 r_out_count;

    logic [HW-1:0]                 r_hist [NUM_BUTTONS];
    logic [HW-1:0]                 n_hist [NUM_BUTTONS];
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    dbcd_pkg::t_digit_pos          r_pos;

    logic                          en_in;
    logic                          en_mid;
    logic                          en_out;
    logic                          adv_mid;
    logic [NUM_BUTTONS-1:0]        press;
    logic [SW-1:0]                 sum;

    logic [17:0]                   p_ten;
    logic [15:0]                   p_hund;
    logic [6:0]                    q_ten;
    logic [3:0]                    q_hund;
    logic [DW-1:0]                 d_units;
    logic [DW-1:0]                 d_tens;
    logic [DW-1:0]                 d_hund;
    logic [DW-1:0]                 d_sel;
    logic                          show;
    logic [dbcd_pkg::ADDR_W-1:0]   addr_sel;
    logic [dbcd_pkg::SEG_W-1:0]    n_seg;
    logic [dbcd_pkg::ADDR_W-1:0]   n_addr;

    assign en_out  = !r_out_v || o_disp.ready;
    assign en_mid  = !r_mid_v || en_out;
    assign en_in   = !r_in_v || en_mid;
    assign adv_mid = r_in_v && en_mid;

    assign i_btn.ready            = en_in;
    assign o_disp.valid           = r_out_v;
    assign o_disp.segment_pattern = r_out_seg;
    assign o_disp.digit_address   = r_out_addr;
    assign o_disp.count_value     = r_out_count;

    // debounce and count update
    always_comb begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            n_hist[i] = {r_hist[i][HW-2:0], r_in_lvl[i]} | dbcd_pkg::HIST_FORCE;
            press[i]  = (n_hist[i] == dbcd_pkg::HIST_ACCEPT);
        end
        sum = {1'b0, r_count} + SW'(press);
        if (sum > dbcd_pkg::COUNT_LIMIT) begin
            n_count = CW'(sum - dbcd_pkg::COUNT_LIMIT);
        end else begin
            n_count = sum[CW-1:0];
        end
    end

    // digit decode
    always_comb begin
        p_ten   = 18'(r_mid_count) * 18'(dbcd_pkg::RECIP_TEN);
        p_hund  = 16'(r_mid_count) * 16'(dbcd_pkg::RECIP_HUND);
        q_ten   = p_ten[dbcd_pkg::RECIP_TEN_SH +: 7];
        q_hund  = p_hund[dbcd_pkg::RECIP_HUND_SH +: 4];
        d_units = DW'(r_mid_count - ({q_ten, 3'b000} + {2'b00, q_ten, 1'b0}));
        d_tens  = DW'(q_ten - ({q_hund, 3'b000} + {2'b00, q_hund, 1'b0}));
        d_hund  = (q_hund >= 4'd10) ? q_hund - 4'd10 : q_hund;
        unique case (r_mid_pos)
            dbcd_pkg::POS_UNITS: begin
                d_sel    = d_units;
                show     = 1'b1;
                addr_sel = dbcd_pkg::ADDR_UNITS;
            end
            dbcd_pkg::POS_TENS: begin
                d_sel    = d_tens;
                show     = r_mid_count >= dbcd_pkg::SHOW_TENS;
                addr_sel = dbcd_pkg::ADDR_TENS;
            end
            dbcd_pkg::POS_HUNDREDS: begin
                d_sel    = d_hund;
                show     = r_mid_count >= dbcd_pkg::SHOW_HUNDREDS;
                addr_sel = dbcd_pkg::ADDR_HUNDREDS;
            end
            dbcd_pkg::POS_THOUSANDS: begin
                d_sel    = DW'(1);
                show     = r_mid_count >= dbcd_pkg::SHOW_THOUSANDS;
                addr_sel = dbcd_pkg::ADDR_THOUSANDS;
            end
            default: begin
                d_sel    = d_units;
                show     = 1'b0;
                addr_sel = dbcd_pkg::BLANK_ADDR;
            end
        endcase
        n_seg  = show ? dbcd_pkg::seg_code(d_sel) : dbcd_pkg::BLANK_CODE;
        n_addr = show ? addr_sel : dbcd_pkg::BLANK_ADDR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_mid_v <= 1'b0;
            r_out_v <= 1'b0;
            r_count <= '0;
            r_pos   <= dbcd_pkg::POS_UNITS;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            if (en_in) begin
                r_in_v <= i_btn.valid;
            end
            if (en_mid) begin
                r_mid_v <= r_in_v;
            end
            if (en_out) begin
                r_out_v <= r_mid_v;
            end
            if (adv_mid) begin
                r_count <= n_count;
                r_pos   <= dbcd_pkg::t_digit_pos'(r_pos + 2'd1);
                for (int i = 0; i < NUM_BUTTONS; i++) begin
                    r_hist[i] <= n_hist[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_in) begin
            r_in_lvl <= i_btn.button_levels[NUM_BUTTONS-1:0];
        end
        if (adv_mid) begin
            r_mid_count <= n_count;
            r_mid_pos   <= r_pos;
        end
        if (en_out) begin
            r_out_seg   <= n_seg;
            r_out_addr  <= n_addr;
            r_out_count <= r_mid_count;
        end
    end

endmodule

// ===== rtl/core/dbcd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbcd_checker
// Port-level checks on the display requests of the counter display unit.
// ----------------------------------------------------------------------------
module dbcd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [dbcd_pkg::SEG_W-1:0]    i_seg,
    input logic [dbcd_pkg::ADDR_W-1:0]   i_addr,
    input logic [dbcd_pkg::COUNT_W-1:0]  i_count
);

    // blank digit always drives the idle decoder address
    a_blank_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_seg == dbcd_pkg::BLANK_CODE |-> i_addr == dbcd_pkg::BLANK_ADDR)
        else $error("blank digit with nonzero address");

    // a shown leading digit needs a count large enough for it
    a_addr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_addr == dbcd_pkg::ADDR_UNITS) ||
            (i_addr == dbcd_pkg::ADDR_TENS && i_count >= dbcd_pkg::SHOW_TENS) ||
            (i_addr == dbcd_pkg::ADDR_HUNDREDS && i_count >= dbcd_pkg::SHOW_HUNDREDS) ||
            (i_addr == dbcd_pkg::ADDR_THOUSANDS && i_count >= dbcd_pkg::SHOW_THOUSANDS))
        else $error("digit address inconsistent with count");

    // thousands digit can only be a one
    a_thousands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_addr == dbcd_pkg::ADDR_THOUSANDS |->
            i_seg == dbcd_pkg::seg_code(4'd1))
        else $error("thousands digit is not one");

    // hold a stalled request
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_seg) && $stable(i_addr) && $stable(i_count))
        else $error("stalled display request changed");

endmodule

bind debounced_button_counter_display_unit dbcd_checker u_dbcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_disp.valid),
    .i_out_ready (o_disp.ready),
    .i_seg       (o_disp.segment_pattern),
    .i_addr      (o_disp.digit_address),
    .i_count     (o_disp.count_value)
);
